[src/invm_pkg.sv]
package invm_pkg;

    localparam int DATA_W = 32;
    localparam int COF_W  = 65;
    localparam int DET_W  = 98;
    localparam int DMAG_W = 97;
    localparam int QBITS  = 33;
    localparam int FRONT_STAGES = 5;

    localparam logic [QBITS-1:0] SAT_POS = 33'h0_7FFF_FFFF;
    localparam logic [QBITS-1:0] SAT_NEG = 33'h0_8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] inv00;
        logic signed [DATA_W-1:0] inv01;
        logic signed [DATA_W-1:0] inv02;
        logic signed [DATA_W-1:0] inv10;
        logic signed [DATA_W-1:0] inv11;
        logic signed [DATA_W-1:0] inv12;
        logic signed [DATA_W-1:0] inv20;
        logic signed [DATA_W-1:0] inv21;
        logic signed [DATA_W-1:0] inv22;
        logic                     singular;
        logic                     overflow;
    } res_t;

    typedef struct packed {
        logic [DMAG_W-1:0] dmag;
        logic              dneg;
        logic              singular;
    } det_info_t;

    typedef logic [8:0][COF_W-1:0] cof_arr_t;

endpackage

[src/invm_cof.sv]
module invm_cof (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  invm_pkg::mat_t        mat,
    output logic                  out_valid,
    output invm_pkg::cof_arr_t    cof,
    output invm_pkg::det_info_t   det_info
);

    localparam int DW = invm_pkg::DATA_W;
    localparam int CW = invm_pkg::COF_W;
    localparam int TW = invm_pkg::DET_W;
    localparam int MW = invm_pkg::DMAG_W;

    logic signed [DW-1:0] m [0:2][0:2];
    logic [invm_pkg::FRONT_STAGES-1:0] vld_reg;

    logic signed [2*DW-1:0] pa_reg [0:8];
    logic signed [2*DW-1:0] pb_reg [0:8];
    logic signed [DW-1:0]   row1_reg [0:2];
    logic signed [DW-1:0]   row2_reg [0:2];

    logic signed [CW-1:0] cof2_reg [0:8];
    logic signed [CW-1:0] cof3_reg [0:8];
    logic signed [CW-1:0] cof4_reg [0:8];
    logic signed [CW-1:0] cof5_reg [0:8];

    logic signed [CW-1:0] ph_reg [0:2];
    logic signed [CW-1:0] pl_reg [0:2];

    logic signed [TW-1:0] det_next;
    logic signed [TW-1:0] det_reg;
    logic signed [TW-1:0] dabs;
    invm_pkg::det_info_t  info_reg;

    assign m[0][0] = mat.m00;
    assign m[0][1] = mat.m01;
    assign m[0][2] = mat.m02;
    assign m[1][0] = mat.m10;
    assign m[1][1] = mat.m11;
    assign m[1][2] = mat.m12;
    assign m[2][0] = mat.m20;
    assign m[2][1] = mat.m21;
    assign m[2][2] = mat.m22;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[invm_pkg::FRONT_STAGES-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        localparam int R1 = (i + 1) % 3;
        localparam int R2 = (i + 2) % 3;
        for (genvar j = 0; j < 3; j++) begin : g_col
            localparam int C1 = (j + 1) % 3;
            localparam int C2 = (j + 2) % 3;
            localparam int K  = i * 3 + j;
            always_ff @(posedge aclk) begin
                if (en) begin
                    pa_reg[K]   <= m[R1][C1] * m[R2][C2];
                    pb_reg[K]   <= m[R1][C2] * m[R2][C1];
                    cof2_reg[K] <= CW'(pa_reg[K]) - CW'(pb_reg[K]);
                    cof3_reg[K] <= cof2_reg[K];
                    cof4_reg[K] <= cof3_reg[K];
                    cof5_reg[K] <= cof4_reg[K];
                end
            end
            assign cof[K] = cof5_reg[K];
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        always_ff @(posedge aclk) begin
            if (en) begin
                row1_reg[j] <= m[0][j];
                row2_reg[j] <= row1_reg[j];
                ph_reg[j]   <= row2_reg[j] * $signed(cof2_reg[j][CW-1:32]);
                pl_reg[j]   <= row2_reg[j] * $signed({1'b0, cof2_reg[j][31:0]});
            end
        end
    end

    always_comb begin
        det_next = (TW'(ph_reg[0]) <<< 32) + (TW'(ph_reg[1]) <<< 32)
                 + (TW'(ph_reg[2]) <<< 32) + TW'(pl_reg[0]) + TW'(pl_reg[1])
                 + TW'(pl_reg[2]);
        dabs = det_reg[TW-1] ? -det_reg : det_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg           <= det_next;
            info_reg.dmag     <= dabs[MW-1:0];
            info_reg.dneg     <= det_reg[TW-1];
            info_reg.singular <= (det_reg == '0);
        end
    end

    assign out_valid = vld_reg[invm_pkg::FRONT_STAGES-1];
    assign det_info  = info_reg;

endmodule

[src/invm_lane.sv]
module invm_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [invm_pkg::COF_W-1:0]     cof,
    input  invm_pkg::det_info_t                   det_info,
    output logic signed [invm_pkg::DATA_W-1:0]    value,
    output logic                                  ovf
);

    localparam int CW     = invm_pkg::COF_W;
    localparam int QB     = invm_pkg::QBITS;
    localparam int MW     = invm_pkg::DMAG_W;
    localparam int NUM_W  = CW + 2 * FRAC_BITS;
    localparam int HEAD_W = NUM_W - QB;
    localparam int CMP_W  = (HEAD_W > MW) ? HEAD_W : MW;

    logic              cneg;
    logic [CW-1:0]     cmag;
    logic [NUM_W-1:0]  num;
    logic [CMP_W-1:0]  head_ext;
    logic              pre_ovf;

    logic [MW-1:0] rem_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic [MW-1:0] dm_reg  [0:QB];
    logic          neg_reg [0:QB];
    logic          pov_reg [0:QB];
    logic          sng_reg [0:QB];

    logic          neg;
    logic          sat;
    logic [QB-1:0] limit;
    logic [QB-1:0] mag;
    logic [QB-1:0] sv;

    always_comb begin
        cneg     = cof[CW-1];
        cmag     = cneg ? CW'(-cof) : CW'(cof);
        num      = NUM_W'(cmag) << (2 * FRAC_BITS);
        head_ext = CMP_W'(num[NUM_W-1:QB]);
        pre_ovf  = head_ext >= CMP_W'(det_info.dmag);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= pre_ovf ? '0 : head_ext[MW-1:0];
            low_reg[0] <= num[QB-1:0];
            q_reg[0]   <= '0;
            dm_reg[0]  <= det_info.dmag;
            neg_reg[0] <= cneg ^ det_info.dneg;
            pov_reg[0] <= pre_ovf;
            sng_reg[0] <= det_info.singular;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [MW:0] trial;
        logic [MW:0] diff;
        logic        ge;

        always_comb begin
            trial = {rem_reg[k-1], low_reg[k-1][QB-1]};
            diff  = trial - {1'b0, dm_reg[k-1]};
            ge    = trial >= {1'b0, dm_reg[k-1]};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[MW-1:0] : trial[MW-1:0];
                low_reg[k] <= low_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                dm_reg[k]  <= dm_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                pov_reg[k] <= pov_reg[k-1];
                sng_reg[k] <= sng_reg[k-1];
            end
        end
    end

    always_comb begin
        neg   = neg_reg[QB] && (pov_reg[QB] || (q_reg[QB] != '0));
        limit = neg ? invm_pkg::SAT_NEG : invm_pkg::SAT_POS;
        sat   = pov_reg[QB] || (q_reg[QB] > limit);
        mag   = sat ? limit : q_reg[QB];
        sv    = neg ? -mag : mag;
        value = sng_reg[QB] ? '0 : $signed(sv[invm_pkg::DATA_W-1:0]);
        ovf   = !sng_reg[QB] && sat;
    end

endmodule

[src/invert_matrix3x3.sv]
// Pipeline: a result is offered once its input transfer has passed through
// 5 cofactor/determinant stages, 34 divider stages and 1 output stage.
// Throughput: one transfer per cycle; the nine divider lanes are fully pipelined
// and the whole pipeline freezes only while a result waits on m_ready.
// Reset: aresetn is synchronous and active low; it clears all valid flags.
module invert_matrix3x3 #(
    parameter int FRAC_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  invm_pkg::mat_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output invm_pkg::res_t  m_data
);

    localparam int QB = invm_pkg::QBITS;
    localparam int DW = invm_pkg::DATA_W;

    logic                 en;
    logic                 front_valid;
    invm_pkg::cof_arr_t   cof;
    invm_pkg::det_info_t  det_info;
    logic [QB:0]          lv_reg;
    logic                 m_valid_reg;
    invm_pkg::res_t       res_next;
    invm_pkg::res_t       res_reg;
    logic [QB:0]          sng_pipe_reg;

    logic signed [DW-1:0] val [0:8];
    logic [8:0]           ovf;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    invm_cof u_cof (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .mat       (s_data),
        .out_valid (front_valid),
        .cof       (cof),
        .det_info  (det_info)
    );

    // Lane (i, j) divides cofactor (j, i), which transposes into the adjugate.
    for (genvar i = 0; i < 3; i++) begin : g_li
        for (genvar j = 0; j < 3; j++) begin : g_lj
            invm_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .aclk     (aclk),
                .en       (en),
                .cof      ($signed(cof[j * 3 + i])),
                .det_info (det_info),
                .value    (val[i * 3 + j]),
                .ovf      (ovf[i * 3 + j])
            );
        end
    end

    always_comb begin
        res_next.inv00    = val[0];
        res_next.inv01    = val[1];
        res_next.inv02    = val[2];
        res_next.inv10    = val[3];
        res_next.inv11    = val[4];
        res_next.inv12    = val[5];
        res_next.inv20    = val[6];
        res_next.inv21    = val[7];
        res_next.inv22    = val[8];
        res_next.overflow = |ovf;
        res_next.singular = sng_pipe_reg[QB];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sng_pipe_reg <= {sng_pipe_reg[QB-1:0], det_info.singular};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            lv_reg      <= {lv_reg[QB-1:0], front_valid};
            m_valid_reg <= lv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

`ifndef SYNTH
    a_sing_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.singular && m_data.overflow))
        else $error("singular result also flags overflow");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.singular) |-> (m_data.inv00 == '0 && m_data.inv11 == '0
            && m_data.inv22 == '0 && m_data.inv01 == '0 && m_data.inv12 == '0))
        else $error("singular result carries nonzero entries");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
